[sv/gaussian_row_filter_rgb_defines.svh]
// assertion macros shared by the filter rtl
`ifndef GAUSSIAN_ROW_FILTER_RGB_DEFINES_SVH
`define GAUSSIAN_ROW_FILTER_RGB_DEFINES_SVH

`ifndef SYNTHESIS

`define GRF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grf assertion failed");

`define GRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grf assertion failed");

`else

`define GRF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define GRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[sv/grf_pkg.sv]
package grf_pkg;

    localparam int unsigned PIX_W       = 8;
    localparam int unsigned PAIR_W      = PIX_W + 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned PROD_W      = CFG_DATA_W + PAIR_W;

    localparam int unsigned DEF_SIDE_TAPS = 4;
    localparam int unsigned DEF_COEF_BITS = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TAP_CENTER,
        CFG_TAP_ONE,
        CFG_TAP_TWO,
        CFG_TAP_THREE,
        CFG_TAP_FOUR
    } t_cfg_addr;

    localparam int unsigned NUM_COEF = 5;

    localparam logic [CFG_DATA_W-1:0] TAP_CENTER_RST = 16'd17432;
    localparam logic [CFG_DATA_W-1:0] TAP_ONE_RST    = 16'd13958;
    localparam logic [CFG_DATA_W-1:0] TAP_TWO_RST    = 16'd7166;
    localparam logic [CFG_DATA_W-1:0] TAP_THREE_RST  = 16'd2359;
    localparam logic [CFG_DATA_W-1:0] TAP_FOUR_RST   = 16'd498;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } t_rgb;

    typedef struct packed {
        logic [PAIR_W-1:0] r;
        logic [PAIR_W-1:0] g;
        logic [PAIR_W-1:0] b;
    } t_pair;

    typedef struct packed {
        logic [PROD_W-1:0] r;
        logic [PROD_W-1:0] g;
        logic [PROD_W-1:0] b;
    } t_prod;

endpackage

[sv/grf_if.sv]
interface grf_pix_in_if;
    logic                        valid;
    logic                        ready;
    logic [grf_pkg::PIX_W-1:0]   red_in;
    logic [grf_pkg::PIX_W-1:0]   green_in;
    logic [grf_pkg::PIX_W-1:0]   blue_in;
    logic                        row_end_in;

    modport source (output valid, red_in, green_in, blue_in, row_end_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, row_end_in, output ready);
endinterface

interface grf_pix_out_if;
    logic                        valid;
    logic                        ready;
    logic [grf_pkg::PIX_W-1:0]   red_out;
    logic [grf_pkg::PIX_W-1:0]   green_out;
    logic [grf_pkg::PIX_W-1:0]   blue_out;
    logic                        row_end_out;

    modport source (output valid, red_out, green_out, blue_out, row_end_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, row_end_out, output ready);
endinterface

interface grf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [grf_pkg::CFG_ADDR_W-1:0]   addr;
    logic [grf_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

[sv/grf_hist_cell.sv]
module grf_hist_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  logic          i_load,
    input  grf_pkg::t_rgb i_prev,
    input  grf_pkg::t_rgb i_bcast,
    output grf_pkg::t_rgb o_q
);

    grf_pkg::t_rgb r_q;

    // row start fills every cell with the first pixel
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_bcast;
        end else if (i_shift) begin
            r_q <= i_prev;
        end
    end

    assign o_q = r_q;

endmodule

[sv/grf_tap_mult.sv]
module grf_tap_mult (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [grf_pkg::CFG_DATA_W-1:0]    i_coef,
    input  grf_pkg::t_pair                    i_pair,
    output grf_pkg::t_prod                    o_prod
);

    grf_pkg::t_prod r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod.r <= grf_pkg::PROD_W'(i_coef) * grf_pkg::PROD_W'(i_pair.r);
            r_prod.g <= grf_pkg::PROD_W'(i_coef) * grf_pkg::PROD_W'(i_pair.g);
            r_prod.b <= grf_pkg::PROD_W'(i_coef) * grf_pkg::PROD_W'(i_pair.b);
        end
    end

    assign o_prod = r_prod;

endmodule

[sv/gaussian_row_filter_rgb.sv]
// timing: a result passes the pair, product, sum and output registers after the shift that completes its
//   window, i.e. SIDE_TAPS pixels after its own pixel, or during the end-of-row flush
// throughput: one pixel per cycle while the output takes results; after an item with row_end_in the input
//   stalls while the history chain shifts the last pixel in again
// reset: coefficients return to their defaults, the row restarts, the pipeline empties
`include "gaussian_row_filter_rgb_defines.svh"

module gaussian_row_filter_rgb #(
    parameter int unsigned SIDE_TAPS = grf_pkg::DEF_SIDE_TAPS,
    parameter int unsigned COEF_BITS = grf_pkg::DEF_COEF_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    grf_pix_in_if.sink    i_pix,
    grf_pix_out_if.source o_pix,
    grf_cfg_if.sink       i_cfg
);

    localparam int unsigned HIST_LEN = 2 * SIDE_TAPS;
    localparam int unsigned FILL_W   = $clog2(SIDE_TAPS + 2);
    localparam int unsigned STEP_W   = $clog2(SIDE_TAPS + 1);
    localparam int unsigned REACH_W  = $clog2(2 * SIDE_TAPS + 2);
    localparam int unsigned SUM_W    = grf_pkg::PROD_W + $clog2(SIDE_TAPS + 1);
    localparam int unsigned PIX_W    = grf_pkg::PIX_W;
    localparam int unsigned PAIR_W   = grf_pkg::PAIR_W;

    // configuration
    logic [grf_pkg::CFG_DATA_W-1:0] r_coef [0:grf_pkg::NUM_COEF-1];
    logic [grf_pkg::CFG_DATA_W-1:0] w_coef [0:SIDE_TAPS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[grf_pkg::CFG_TAP_CENTER] <= grf_pkg::TAP_CENTER_RST;
            r_coef[grf_pkg::CFG_TAP_ONE]    <= grf_pkg::TAP_ONE_RST;
            r_coef[grf_pkg::CFG_TAP_TWO]    <= grf_pkg::TAP_TWO_RST;
            r_coef[grf_pkg::CFG_TAP_THREE]  <= grf_pkg::TAP_THREE_RST;
            r_coef[grf_pkg::CFG_TAP_FOUR]   <= grf_pkg::TAP_FOUR_RST;
        end else if (i_cfg.valid && (i_cfg.addr <= grf_pkg::CFG_TAP_FOUR)) begin
            r_coef[i_cfg.addr] <= i_cfg.data;
        end
    end

    for (genvar i = 0; i <= SIDE_TAPS; i++) begin : g_coef
        if (i < grf_pkg::NUM_COEF) begin : g_reg
            assign w_coef[i] = r_coef[i];
        end else begin : g_zero
            assign w_coef[i] = '0;
        end
    end

    // row control
    logic [FILL_W-1:0]  r_fill;
    logic [STEP_W-1:0]  r_step;
    logic               r_flushing;
    logic [FILL_W-1:0]  w_fill_inc;
    logic [REACH_W-1:0] w_reach;
    logic               w_start;
    logic               w_emit;
    logic               w_row_end;
    logic               w_go;
    logic               w_acc;

    logic r_v1, r_v2, r_v3, r_ov;
    logic w_ld1, w_ld2, w_ld3, w_ldo;

    assign w_ldo = !r_ov || o_pix.ready;
    assign w_ld3 = !r_v3 || w_ldo;
    assign w_ld2 = !r_v2 || w_ld3;
    assign w_ld1 = !r_v1 || w_ld2;

    assign i_pix.ready = w_ld1 && !r_flushing;
    assign w_acc       = i_pix.valid && i_pix.ready;
    assign w_go        = w_ld1 && (r_flushing || i_pix.valid);

    assign w_start    = (r_fill == '0);
    assign w_fill_inc = (r_fill < FILL_W'(SIDE_TAPS + 1)) ? r_fill + FILL_W'(1) : r_fill;
    assign w_reach    = REACH_W'(r_fill) + REACH_W'(r_step);
    assign w_row_end  = r_flushing && (r_step == STEP_W'(SIDE_TAPS));
    assign w_emit     = r_flushing ? (w_reach >= REACH_W'(SIDE_TAPS + 1))
                                   : (w_fill_inc == FILL_W'(SIDE_TAPS + 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_step     <= '0;
            r_flushing <= 1'b0;
        end else if (w_go) begin
            if (r_flushing) begin
                if (w_row_end) begin
                    r_flushing <= 1'b0;
                    r_fill     <= '0;
                end else begin
                    r_step <= r_step + STEP_W'(1);
                end
            end else begin
                r_fill <= w_fill_inc;
                if (i_pix.row_end_in) begin
                    r_flushing <= 1'b1;
                    r_step     <= STEP_W'(1);
                end
            end
        end
    end

    // history chain, oldest sample in cell 0
    grf_pkg::t_rgb w_x;
    grf_pkg::t_rgb w_hist [0:HIST_LEN-1];
    grf_pkg::t_rgb w_win  [0:HIST_LEN];

    assign w_x = r_flushing ? w_hist[HIST_LEN-1]
                            : grf_pkg::t_rgb'{i_pix.red_in, i_pix.green_in, i_pix.blue_in};

    for (genvar k = 0; k < HIST_LEN; k++) begin : g_cell
        grf_pkg::t_rgb w_prev;
        if (k == HIST_LEN - 1) begin : g_head
            assign w_prev = w_x;
        end else begin : g_body
            assign w_prev = w_hist[k+1];
        end

        grf_hist_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_go),
            .i_load  (w_go && w_start),
            .i_prev  (w_prev),
            .i_bcast (w_x),
            .o_q     (w_hist[k])
        );

        assign w_win[k] = w_start ? w_x : w_hist[k];
    end
    assign w_win[HIST_LEN] = w_x;

    // stage 1: symmetric pair sums
    grf_pkg::t_pair r1_pair [0:SIDE_TAPS];
    logic           r_last1, r_last2, r_last3;

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_last1 <= w_row_end;
            r1_pair[0].r <= PAIR_W'(w_win[SIDE_TAPS].r);
            r1_pair[0].g <= PAIR_W'(w_win[SIDE_TAPS].g);
            r1_pair[0].b <= PAIR_W'(w_win[SIDE_TAPS].b);
            for (int i = 1; i <= SIDE_TAPS; i++) begin
                r1_pair[i].r <= PAIR_W'(w_win[SIDE_TAPS-i].r) + PAIR_W'(w_win[SIDE_TAPS+i].r);
                r1_pair[i].g <= PAIR_W'(w_win[SIDE_TAPS-i].g) + PAIR_W'(w_win[SIDE_TAPS+i].g);
                r1_pair[i].b <= PAIR_W'(w_win[SIDE_TAPS-i].b) + PAIR_W'(w_win[SIDE_TAPS+i].b);
            end
        end
    end

    // stage 2: one multiplier cell per distance
    grf_pkg::t_prod w_prod [0:SIDE_TAPS];

    for (genvar i = 0; i <= SIDE_TAPS; i++) begin : g_tap
        grf_tap_mult u_tap (
            .i_clk  (i_clk),
            .i_en   (w_ld2),
            .i_coef (w_coef[i]),
            .i_pair (r1_pair[i]),
            .o_prod (w_prod[i])
        );
    end

    // stage 3: sum of products
    logic [SUM_W-1:0] w_sum_r, w_sum_g, w_sum_b;
    logic [SUM_W-1:0] r3_r, r3_g, r3_b;

    always_comb begin
        w_sum_r = '0;
        w_sum_g = '0;
        w_sum_b = '0;
        for (int i = 0; i <= SIDE_TAPS; i++) begin
            w_sum_r = w_sum_r + SUM_W'(w_prod[i].r);
            w_sum_g = w_sum_g + SUM_W'(w_prod[i].g);
            w_sum_b = w_sum_b + SUM_W'(w_prod[i].b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_last2 <= r_last1;
        end
        if (w_ld3) begin
            r_last3 <= r_last2;
            r3_r    <= w_sum_r;
            r3_g    <= w_sum_g;
            r3_b    <= w_sum_b;
        end
    end

    // output: scale down and saturate
    logic [SUM_W-1:0] w_sh_r, w_sh_g, w_sh_b;
    logic [PIX_W-1:0] w_sat_r, w_sat_g, w_sat_b;
    logic [PIX_W-1:0] r_o_red, r_o_green, r_o_blue;
    logic             r_o_row_end;

    assign w_sh_r  = r3_r >> COEF_BITS;
    assign w_sh_g  = r3_g >> COEF_BITS;
    assign w_sh_b  = r3_b >> COEF_BITS;
    assign w_sat_r = (w_sh_r > SUM_W'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : w_sh_r[PIX_W-1:0];
    assign w_sat_g = (w_sh_g > SUM_W'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : w_sh_g[PIX_W-1:0];
    assign w_sat_b = (w_sh_b > SUM_W'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : w_sh_b[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_ldo) begin
            r_o_red     <= w_sat_r;
            r_o_green   <= w_sat_g;
            r_o_blue    <= w_sat_b;
            r_o_row_end <= r_last3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_ld1) begin
                r_v1 <= w_go && w_emit;
            end
            if (w_ld2) begin
                r_v2 <= r_v1;
            end
            if (w_ld3) begin
                r_v3 <= r_v2;
            end
            if (w_ldo) begin
                r_ov <= r_v3;
            end
        end
    end

    assign o_pix.valid       = r_ov;
    assign o_pix.red_out     = r_o_red;
    assign o_pix.green_out   = r_o_green;
    assign o_pix.blue_out    = r_o_blue;
    assign o_pix.row_end_out = r_o_row_end;

    `GRF_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(SIDE_TAPS + 1))
    `GRF_ASSERT_NEXT(a_flush_start, i_clk, i_rst_n, w_acc && i_pix.row_end_in, r_flushing)
    `GRF_ASSERT_IMPL(a_last_shift_emits, i_clk, i_rst_n, w_go && w_row_end, w_emit)
    `GRF_ASSERT_IMPL(a_flush_has_fill, i_clk, i_rst_n, r_flushing, r_fill != '0)

endmodule
